>>> sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared types and constants for the sextant HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam logic [11:0] HUE_FULL        = 12'd3600;
    localparam logic [14:0] FRAC_RECIP      = 15'd27963;
    localparam logic [15:0] FULL_SCALE      = 16'd65280;
    localparam logic [8:0]  FRAC_ONE        = 9'd256;
    localparam int          QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    typedef struct packed {
        t_sector     sector;
        logic [7:0]  frac;
        logic [7:0]  sat;
        logic [7:0]  val;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    function automatic logic [11:0] sector_base(input t_sector sec);
        logic [11:0] base;
        case (sec)
            SEC_RED:     base = 12'd0;
            SEC_YELLOW:  base = 12'd600;
            SEC_GREEN:   base = 12'd1200;
            SEC_CYAN:    base = 12'd1800;
            SEC_BLUE:    base = 12'd2400;
            SEC_MAGENTA: base = 12'd3000;
            default:     base = 12'd0;
        endcase
        return base;
    endfunction

endpackage
`default_nettype wire

>>> sv/hsv2rgb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB stream interfaces
// Valid/ready channels for HSV pixels in and packed RGB words out.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface hsv2rgb_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);
endinterface
`default_nettype wire

>>> sv/hsv2rgb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Accepts HSV beats, wraps the hue, finds the sector and its 8-bit fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    hsv2rgb_in_if.sink                 i_pix,
    input  hsv2rgb_pkg::t_queue_stat   i_stat,
    output logic                       o_push,
    output hsv2rgb_pkg::t_work         o_work
);
    import hsv2rgb_pkg::*;

    logic [11:0] hue_w;
    logic [11:0] rem_w;
    t_sector     sec;
    logic [24:0] frac_prod;

    logic        r_f1_valid;
    logic        n_f1_valid;
    t_sector     r_f1_sector;
    logic [9:0]  r_f1_rem;
    logic [7:0]  r_f1_sat;
    logic [7:0]  r_f1_val;

    always_comb begin
        hue_w = (i_pix.hue >= HUE_FULL) ? 12'(i_pix.hue - HUE_FULL) : i_pix.hue;
        if (hue_w >= sector_base(SEC_MAGENTA)) begin
            sec = SEC_MAGENTA;
        end else if (hue_w >= sector_base(SEC_BLUE)) begin
            sec = SEC_BLUE;
        end else if (hue_w >= sector_base(SEC_CYAN)) begin
            sec = SEC_CYAN;
        end else if (hue_w >= sector_base(SEC_GREEN)) begin
            sec = SEC_GREEN;
        end else if (hue_w >= sector_base(SEC_YELLOW)) begin
            sec = SEC_YELLOW;
        end else begin
            sec = SEC_RED;
        end
        rem_w = 12'(hue_w - sector_base(sec));
    end

    assign i_pix.ready = !r_f1_valid || !i_stat.full;
    assign o_push      = r_f1_valid && !i_stat.full;
    assign n_f1_valid  = i_pix.ready ? i_pix.valid : r_f1_valid;

    // frac = floor(rem * 256 / 600) by reciprocal multiply
    assign frac_prod      = 25'(r_f1_rem) * 25'(FRAC_RECIP);
    assign o_work.sector  = r_f1_sector;
    assign o_work.frac    = frac_prod[23:16];
    assign o_work.sat     = r_f1_sat;
    assign o_work.val     = r_f1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= n_f1_valid;
        end
        if (i_pix.valid && i_pix.ready) begin
            r_f1_sector <= sec;
            r_f1_rem    <= rem_w[9:0];
            r_f1_sat    <= i_pix.saturation;
            r_f1_val    <= i_pix.brightness;
        end
    end

endmodule
`default_nettype wire

>>> sv/hsv2rgb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB work queue
// Short FIFO of classified pixels between the front end and the back end.
// ----------------------------------------------------------------------------
module hsv2rgb_queue #(
    parameter int DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  hsv2rgb_pkg::t_work         i_data,
    input  wire                        i_pop,
    output hsv2rgb_pkg::t_work         o_data,
    output hsv2rgb_pkg::t_queue_stat   o_stat
);
    import hsv2rgb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work          r_slot [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [AW-1:0]  n_wr_ptr;
    logic [AW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("queue count missed a push");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("queue count missed a pop");
`endif

endmodule
`default_nettype wire

>>> sv/hsv2rgb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Forms p, q and t over three stages, permutes the channels, packs RGB.
// ----------------------------------------------------------------------------
module hsv2rgb_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  hsv2rgb_pkg::t_work         i_work,
    input  hsv2rgb_pkg::t_queue_stat   i_stat,
    output logic                       o_pop,
    hsv2rgb_out_if.source              o_rgb
);
    import hsv2rgb_pkg::*;

    // floor(x / 255) for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic        adv3;
    logic        b2_ready;
    logic        b1_ready;

    logic [8:0]  inv_f;
    logic [15:0] sf;
    logic [16:0] s_inv_f;

    logic        r_b1_valid;
    t_sector     r_b1_sector;
    logic [7:0]  r_b1_val;
    logic [7:0]  r_b1_inv_s;
    logic [15:0] r_b1_num_q;
    logic [15:0] r_b1_num_t;

    logic [15:0] prod_p;
    logic [23:0] prod_q;
    logic [23:0] prod_t;

    logic        r_b2_valid;
    t_sector     r_b2_sector;
    logic [7:0]  r_b2_val;
    logic [15:0] r_b2_prod_p;
    logic [15:0] r_b2_prod_q;
    logic [15:0] r_b2_prod_t;

    logic [7:0]  lvl_p;
    logic [7:0]  lvl_q;
    logic [7:0]  lvl_t;
    logic [23:0] n_color;

    logic        r_o_valid;
    logic [23:0] r_o_color;

    assign adv3     = !r_o_valid || o_rgb.ready;
    assign b2_ready = !r_b2_valid || adv3;
    assign b1_ready = !r_b1_valid || b2_ready;
    assign o_pop    = !i_stat.empty && b1_ready;

    assign inv_f   = 9'(FRAC_ONE - 9'(i_work.frac));
    assign sf      = 16'(i_work.sat) * 16'(i_work.frac);
    assign s_inv_f = 17'(i_work.sat) * 17'(inv_f);

    assign prod_p = 16'(r_b1_val) * 16'(r_b1_inv_s);
    assign prod_q = 24'(r_b1_val) * 24'(r_b1_num_q);
    assign prod_t = 24'(r_b1_val) * 24'(r_b1_num_t);

    always_comb begin
        lvl_p = div255(r_b2_prod_p);
        lvl_q = div255(r_b2_prod_q);
        lvl_t = div255(r_b2_prod_t);
        case (r_b2_sector)
            SEC_RED:    n_color = {r_b2_val, lvl_t, lvl_p};
            SEC_YELLOW: n_color = {lvl_q, r_b2_val, lvl_p};
            SEC_GREEN:  n_color = {lvl_p, r_b2_val, lvl_t};
            SEC_CYAN:   n_color = {lvl_p, lvl_q, r_b2_val};
            SEC_BLUE:   n_color = {lvl_t, lvl_p, r_b2_val};
            default:    n_color = {r_b2_val, lvl_p, lvl_q};
        endcase
    end

    assign o_rgb.valid = r_o_valid;
    assign o_rgb.color = r_o_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= o_pop;
            end
            if (b2_ready) begin
                r_b2_valid <= r_b1_valid;
            end
            if (adv3) begin
                r_o_valid <= r_b2_valid;
            end
        end
        if (o_pop) begin
            r_b1_sector <= i_work.sector;
            r_b1_val    <= i_work.val;
            r_b1_inv_s  <= ~i_work.sat;
            r_b1_num_q  <= 16'(FULL_SCALE - sf);
            r_b1_num_t  <= 16'(17'(FULL_SCALE) - s_inv_f);
        end
        if (b2_ready && r_b1_valid) begin
            r_b2_sector <= r_b1_sector;
            r_b2_val    <= r_b1_val;
            r_b2_prod_p <= prod_p;
            r_b2_prod_q <= prod_q[23:8];
            r_b2_prod_t <= prod_t[23:8];
        end
        if (adv3 && r_b2_valid) begin
            r_o_color <= n_color;
        end
    end

`ifndef SYNTHESIS
    a_b2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b2_valid && !adv3) |=> (r_b2_valid && $stable(r_b2_prod_q)))
        else $error("stalled product stage lost its beat");
    a_b1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !b2_ready) |=> (r_b1_valid && $stable(r_b1_num_t)))
        else $error("stalled numerator stage lost its beat");
`endif

endmodule
`default_nettype wire

>>> sv/hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Sextant HSV to packed 24-bit RGB conversion, one pixel per clock while the sink is ready.
// ----------------------------------------------------------------------------
// Takes one HSV beat per clock and returns one RGB beat per clock when the
// sink keeps ready high. A beat passes through one front register (hue wrap
// and sector search), one queue slot, then three back-end stages (saturation
// products, brightness products, divide by 255 and channel select).
// Throughput is set by the back-end product pipeline, which takes a new pixel
// every cycle while the output side is not stalling. The queue lets the front
// end keep taking beats while the output side stalls, until the queue fills.
// No clearing pass after reset.
module hsv_to_rgb_converter_unit #(
    parameter int QUEUE_DEPTH = hsv2rgb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    hsv2rgb_in_if.sink      i_pix,
    hsv2rgb_out_if.source   o_rgb
);
    import hsv2rgb_pkg::*;

    t_work       front_work;
    t_work       queue_work;
    t_queue_stat queue_stat;
    logic        push;
    logic        pop;

    hsv2rgb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_stat  (queue_stat),
        .o_push  (push),
        .o_work  (front_work)
    );

    hsv2rgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_work),
        .i_pop   (pop),
        .o_data  (queue_work),
        .o_stat  (queue_stat)
    );

    hsv2rgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (queue_work),
        .i_stat  (queue_stat),
        .o_pop   (pop),
        .o_rgb   (o_rgb)
    );

endmodule
`default_nettype wire

>>> tb/sv/hsv_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter unit testbench
// Streams HSV pixels through the converter: sector edges, hue wrap and the
// saturation and brightness extremes first, then random pixels. Each RGB beat
// is checked against a fixed-point sextant predictor. Both sides of the
// handshake idle at random in two phases; a third phase has no idling.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit_tb;

    import hsv2rgb_pkg::*;

    localparam int unsigned HUE_PER_SECTOR = 600;
    localparam int unsigned UNIT_LEVEL     = 255;
    localparam int          RANDOM_PIXELS  = 729;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          TIMEOUT_NS     = 2_000_000;

    class color_ledger;
        logic [23:0] pending_colors[$];
        int          mismatches = 0;

        function automatic logic [23:0] hsv_to_color(input logic [11:0] hue,
                                                     input logic [7:0]  sat,
                                                     input logic [7:0]  val);
            int unsigned h, s, v, f, p, q, t, full, one;
            logic [7:0]  r, g, b;
            t_sector     sec;
            h    = 32'(hue);
            s    = 32'(sat);
            v    = 32'(val);
            full = 32'(FULL_SCALE);
            one  = 32'(FRAC_ONE);
            if (h >= 32'(HUE_FULL)) begin
                h = h - 32'(HUE_FULL);
            end
            sec = t_sector'(3'(h / HUE_PER_SECTOR));
            f   = ((h % HUE_PER_SECTOR) * one) / HUE_PER_SECTOR;
            p   = (v * (UNIT_LEVEL - s)) / UNIT_LEVEL;
            q   = (v * (full - s * f)) / full;
            t   = (v * (full - s * (one - f))) / full;
            case (sec)
                SEC_RED: begin
                    r = v[7:0]; g = t[7:0]; b = p[7:0];
                end
                SEC_YELLOW: begin
                    r = q[7:0]; g = v[7:0]; b = p[7:0];
                end
                SEC_GREEN: begin
                    r = p[7:0]; g = v[7:0]; b = t[7:0];
                end
                SEC_CYAN: begin
                    r = p[7:0]; g = q[7:0]; b = v[7:0];
                end
                SEC_BLUE: begin
                    r = t[7:0]; g = p[7:0]; b = v[7:0];
                end
                default: begin
                    r = v[7:0]; g = p[7:0]; b = q[7:0];
                end
            endcase
            return {r, g, b};
        endfunction

        function void note_pixel(input logic [11:0] hue, input logic [7:0] sat,
                                 input logic [7:0] val);
            pending_colors.push_back(hsv_to_color(hue, sat, val));
        endfunction

        function void check_color(input logic [23:0] color);
            logic [23:0] want;
            if (pending_colors.size() == 0) begin
                $error("color: unexpected beat, actual %06h", color);
                mismatches++;
            end else begin
                want = pending_colors.pop_front();
                if (color !== want) begin
                    $error("color: expected %06h, actual %06h", want, color);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int src_gap_pct    = 29;
    int sink_stall_pct = 48;

    color_ledger ledger = new();

    hsv2rgb_in_if  pix_if ();
    hsv2rgb_out_if rgb_if ();

    hsv_to_rgb_converter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_rgb   (rgb_if)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        pix_if.valid      = 1'b0;
        pix_if.hue        = '0;
        pix_if.saturation = '0;
        pix_if.brightness = '0;
        rgb_if.ready      = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rgb_if.valid && rgb_if.ready) begin
            ledger.check_color(rgb_if.color);
        end
        rgb_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_pixel(input logic [11:0] hue, input logic [7:0] sat,
                              input logic [7:0] val);
        while ($urandom_range(99) < src_gap_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.hue        <= hue;
        pix_if.saturation <= sat;
        pix_if.brightness <= val;
        @(posedge i_clk);
        while (!pix_if.ready) begin
            @(posedge i_clk);
        end
        ledger.note_pixel(hue, sat, val);
    endtask

    initial begin
        logic [11:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sector edges at full saturation and brightness
        send_pixel(12'd0,    8'd255, 8'd255);
        send_pixel(12'd599,  8'd255, 8'd255);
        send_pixel(12'd600,  8'd255, 8'd255);
        send_pixel(12'd1199, 8'd255, 8'd255);
        send_pixel(12'd1200, 8'd255, 8'd255);
        send_pixel(12'd1799, 8'd255, 8'd255);
        send_pixel(12'd1800, 8'd255, 8'd255);
        send_pixel(12'd2399, 8'd255, 8'd255);
        send_pixel(12'd2400, 8'd255, 8'd255);
        send_pixel(12'd2999, 8'd255, 8'd255);
        send_pixel(12'd3000, 8'd255, 8'd255);
        send_pixel(12'd3599, 8'd255, 8'd255);
        // hue wrap
        send_pixel(12'd3600, 8'd255, 8'd255);
        send_pixel(12'd4095, 8'd255, 8'd255);
        send_pixel(12'd3900, 8'd200, 8'd180);
        // zero saturation gives grey, then mixed saturation and brightness levels
        send_pixel(12'd1000, 8'd0,   8'd200);
        send_pixel(12'd4095, 8'd0,   8'd255);
        send_pixel(12'd0,    8'd0,   8'd0);
        send_pixel(12'd2100, 8'd255, 8'd0);
        send_pixel(12'd300,  8'd128, 8'd255);
        send_pixel(12'd1234, 8'd1,   8'd254);
        send_pixel(12'd3300, 8'd170, 8'd85);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i == RANDOM_PIXELS / 3) begin
                src_gap_pct    = 48;
                sink_stall_pct = 29;
            end else if (i == 2 * RANDOM_PIXELS / 3) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            hue = ($urandom_range(9) == 0) ? 12'($urandom_range(4095, 3600))
                                           : 12'($urandom_range(3599));
            case ($urandom_range(9))
                0:       sat = 8'd0;
                1:       sat = 8'd255;
                default: sat = 8'($urandom_range(255));
            endcase
            case ($urandom_range(9))
                0:       val = 8'd0;
                1:       val = 8'd255;
                default: val = 8'($urandom_range(255));
            endcase
            send_pixel(hue, sat, val);
        end
        pix_if.valid <= 1'b0;

        while (ledger.pending_colors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
